>>> rtl/core/rapqt_pkg.sv
// types and constants shared by the range add / point query tree
package rapqt_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 32;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_RN   = 8'b0000_0100,
		S_RL   = 8'b0000_1000,
		S_RR   = 8'b0001_0000,
		S_WN   = 8'b0010_0000,
		S_WL   = 8'b0100_0000,
		S_WR   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic [POS_W-1:0] nlo;
		logic [POS_W-1:0] nhi;
	} span_t;

endpackage

>>> rtl/core/range_add_point_query_tree.sv
// Range add / point query interval tree over positions 1..size_in_use.
// Requests arrive on req_valid / req_stall with cmd, first_index, last_index,
// increment and query_index as one beat; a beat is taken when req_valid is
// high and req_stall low. A range add gives no result; a point query gives
// one beat of point_value on rsp_valid / rsp_stall. Add ranges that are
// reversed or outside 1..size are dropped; query positions are clamped.
// size_in_use is written through size_we / size_wdata; the user writes it
// only while the block idles, which the block itself does not enforce.
// The pending values live in one 2*LEAVES x 32 memory with registered reads.
// Each visited node steps through S_RN, S_RL, S_RR (three reads) and S_WN,
// S_WL, S_WR (three writes), one node at a time; a covered node or the
// final leaf takes only S_RN and S_RL. A query visits up to ceil(log2(size))+1
// nodes; an add visits up to two root-to-leaf paths. The next request is
// taken when the current one is finished. After reset the memory is cleared,
// one entry a cycle, with req_stall high; size_in_use returns to 1024.
// A finished result waits in the output register while rsp_stall is high;
// a query reaching its leaf holds there until that register is free.
module range_add_point_query_tree
	import rapqt_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             size_we,
	input  logic [POS_W-1:0] size_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             cmd,
	input  logic [POS_W-1:0] first_index,
	input  logic [POS_W-1:0] last_index,
	input  logic signed [VAL_W-1:0] increment,
	input  logic [POS_W-1:0] query_index,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic signed [VAL_W-1:0] point_value
);

	localparam int NAW   = $clog2(LEAVES) + 1;
	localparam int DEPTH = 2 ** NAW;

	state_t           state_q;
	logic [NAW-1:0]   clr_q;
	logic [POS_W-1:0] size_q;
	logic [POS_W-1:0] n;
	logic             cmd_q;
	logic [VAL_W-1:0] inc_q;
	span_t            sp_q;
	logic [NAW-1:0]   node_q;
	span_t            sav_sp_q;
	logic [NAW-1:0]   sav_node_q;
	logic             sav_v_q;
	logic [VAL_W-1:0] pn_q, pl_q, pr_q;
	logic             rsp_valid_q;
	logic [VAL_W-1:0] point_value_q;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic             mem_we, mem_re;
	logic [NAW-1:0]   waddr, raddr;
	logic [VAL_W-1:0] wdata;

	logic [NAW-1:0]   lchild, rchild;
	logic [POS_W-1:0] mid;
	logic             full;
	logic             go_left, go_right, addl, addr_r, split_save;
	span_t            lsp, rsp;
	logic             accept, req_ok;
	logic [POS_W-1:0] qpos;

	always_comb begin
		if (size_q == '0)
			n = POS_W'(1);
		else if (32'(size_q) > 32'(LEAVES))
			n = POS_W'(LEAVES);
		else
			n = size_q;
	end

	assign lchild = {node_q[NAW-2:0], 1'b0};
	assign rchild = {node_q[NAW-2:0], 1'b1};
	assign mid    = POS_W'(({1'b0, sp_q.nlo} + {1'b0, sp_q.nhi}) >> 1);
	assign full   = (sp_q.lo == sp_q.nlo) && (sp_q.hi == sp_q.nhi);

	always_comb begin
		go_left    = 1'b0;
		go_right   = 1'b0;
		addl       = 1'b0;
		addr_r     = 1'b0;
		split_save = 1'b0;
		lsp        = '{lo: sp_q.lo, hi: sp_q.hi, nlo: sp_q.nlo, nhi: mid};
		rsp        = '{lo: sp_q.lo, hi: sp_q.hi, nlo: mid + POS_W'(1), nhi: sp_q.nhi};
		if (sp_q.hi <= mid) begin
			go_left = 1'b1;
		end else if (sp_q.lo > mid) begin
			go_right = 1'b1;
		end else if (sp_q.lo == sp_q.nlo) begin
			addl     = 1'b1;
			go_right = 1'b1;
			rsp.lo   = mid + POS_W'(1);
		end else if (sp_q.hi == sp_q.nhi) begin
			addr_r  = 1'b1;
			go_left = 1'b1;
			lsp.hi  = mid;
		end else begin
			split_save = 1'b1;
			go_left    = 1'b1;
			lsp.hi     = mid;
			rsp.lo     = mid + POS_W'(1);
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign req_ok    = (first_index != '0) && (last_index <= n) && (first_index <= last_index);
	assign qpos      = (query_index == '0) ? POS_W'(1) : ((query_index > n) ? n : query_index);

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = node_q;
		raddr  = node_q;
		wdata  = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
			end
			S_RN: mem_re = 1'b1;
			S_RL: begin
				if (full) begin
					if (cmd_q == CMD_ADD) begin
						mem_we = 1'b1;
						wdata  = rdata_q + inc_q;
					end
				end else begin
					mem_re = 1'b1;
					raddr  = lchild;
				end
			end
			S_RR: begin
				mem_re = 1'b1;
				raddr  = rchild;
			end
			S_WN: mem_we = 1'b1;
			S_WL: begin
				mem_we = 1'b1;
				waddr  = lchild;
				wdata  = pl_q + pn_q + (addl ? inc_q : '0);
			end
			S_WR: begin
				mem_we = 1'b1;
				waddr  = rchild;
				wdata  = pr_q + pn_q + (addr_r ? inc_q : '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cmd_q <= cmd;
			inc_q <= increment;
		end
		unique case (state_q)
			S_RL: pn_q <= rdata_q;
			S_RR: pl_q <= rdata_q;
			S_WN: pr_q <= rdata_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			size_q        <= SIZE_RESET;
			sp_q          <= '0;
			node_q        <= '0;
			sav_sp_q      <= '0;
			sav_node_q    <= '0;
			sav_v_q       <= 1'b0;
			rsp_valid_q   <= 1'b0;
			point_value_q <= '0;
		end else begin
			if (size_we)
				size_q <= size_wdata;
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NAW'(1);
					if (clr_q == NAW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						node_q  <= NAW'(1);
						sav_v_q <= 1'b0;
						if (cmd == CMD_QUERY) begin
							sp_q    <= '{lo: qpos, hi: qpos, nlo: POS_W'(1), nhi: n};
							state_q <= S_RN;
						end else if (req_ok) begin
							sp_q    <= '{lo: first_index, hi: last_index, nlo: POS_W'(1), nhi: n};
							state_q <= S_RN;
						end
					end
				end
				S_RN: state_q <= S_RL;
				S_RL: begin
					if (full) begin
						if (cmd_q == CMD_QUERY) begin
							if (!rsp_valid_q || !rsp_stall) begin
								rsp_valid_q   <= 1'b1;
								point_value_q <= rdata_q;
								state_q       <= S_IDLE;
							end
						end else if (sav_v_q) begin
							sp_q    <= sav_sp_q;
							node_q  <= sav_node_q;
							sav_v_q <= 1'b0;
							state_q <= S_RN;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_RR;
					end
				end
				S_RR: state_q <= S_WN;
				S_WN: state_q <= S_WL;
				S_WL: state_q <= S_WR;
				S_WR: begin
					if (split_save) begin
						sav_sp_q   <= rsp;
						sav_node_q <= rchild;
						sav_v_q    <= 1'b1;
					end
					if (go_left) begin
						sp_q   <= lsp;
						node_q <= lchild;
					end else if (go_right) begin
						sp_q   <= rsp;
						node_q <= rchild;
					end
					state_q <= S_RN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign point_value = point_value_q;

`ifndef SYNTHESIS
	// the single saved path is never overwritten while still waiting
	a_save_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && split_save) |-> !sav_v_q)
		else $error("saved path overwritten");

	// no memory write while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory write while idle");

	// the node is cleared only after all three reads of its spread
	a_spread_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WN) |-> ($past(state_q) == S_RR))
		else $error("spread write out of order");

	// a walk never steps outside the node span
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RN) |-> (sp_q.nlo <= sp_q.lo) && (sp_q.hi <= sp_q.nhi)
		&& (sp_q.lo <= sp_q.hi))
		else $error("range outside node span");

	// a result appears only when a query finishes its walk
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_RL) && (cmd_q == CMD_QUERY))
		else $error("unexpected result beat");
`endif

endmodule
